### design/indexed_array_insert_delete_search_defines.svh
// Assertion macros used by the checker file.
// Depends on a clk and an arst_n signal in the scope of use.
`ifndef INDEXED_ARRAY_INSERT_DELETE_SEARCH_DEFINES_SVH
`define INDEXED_ARRAY_INSERT_DELETE_SEARCH_DEFINES_SVH

// same-cycle implication
`define IAIDS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iaids assertion failed");

// next-cycle implication
`define IAIDS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iaids assertion failed");

`endif

### design/iaids_pkg.sv
// Package for the indexed array block: sizes, command and status codes, queue item type.
// No dependencies.
package iaids_pkg;
	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int MAX_RES = 16;

	localparam logic [2:0] CMD_INS  = 3'd0;
	localparam logic [2:0] CMD_DEL  = 3'd1;
	localparam logic [2:0] CMD_LSR  = 3'd2;
	localparam logic [2:0] CMD_BSR  = 3'd3;
	localparam logic [2:0] CMD_DISP = 3'd4;

	typedef enum logic [2:0] {
		OP_INS, OP_DEL, OP_LSR, OP_BSR, OP_DISP
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BADIDX   = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SHIFT, S_LSRCH, S_BRD, S_BCMP, S_DRD, S_EMIT
	} bstate_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  index;
		logic [31:0] value;
		logic [31:0] key;
	} item_t;
endpackage

### design/iaids_ifs.sv
// Channel interfaces for the indexed array block: command beats in, result beats out.
// No dependencies.
interface iaids_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic [3:0]         index;
	logic signed [31:0] value;
	logic signed [31:0] key;
	modport source (output valid, cmd, index, value, key, input ready);
	modport sink (input valid, cmd, index, value, key, output ready);
endinterface

interface iaids_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [3:0]         position;
	logic signed [31:0] data;
	logic [4:0]         count;
	logic               last;
	modport source (output valid, status, position, data, count, last, input ready);
	modport sink (input valid, status, position, data, count, last, output ready);
endinterface

### design/iaids_front.sv
// Front part: accepts command beats, decodes them, drops unused codes, queues two deep.
// Depends on iaids_pkg and iaids_ifs.
module iaids_front (
	input  logic               clk,
	input  logic               arst_n,
	iaids_req_if.sink          request,
	output iaids_pkg::item_t   head,
	output logic               head_valid,
	input  logic               pop
);
	iaids_pkg::item_t ent_q [2];
	logic             rd_q;
	logic             wr_q;
	logic [1:0]       fill_q;
	logic             push;
	logic             legal;
	iaids_pkg::item_t dec;

	assign request.ready = (fill_q != 2'd2);
	assign head          = ent_q[rd_q];
	assign head_valid    = (fill_q != 2'd0);

	always_comb begin
		legal     = 1'b1;
		dec.op    = iaids_pkg::OP_INS;
		dec.index = request.index;
		dec.value = request.value;
		dec.key   = request.key;
		case (request.cmd)
			iaids_pkg::CMD_INS:  dec.op = iaids_pkg::OP_INS;
			iaids_pkg::CMD_DEL:  dec.op = iaids_pkg::OP_DEL;
			iaids_pkg::CMD_LSR:  dec.op = iaids_pkg::OP_LSR;
			iaids_pkg::CMD_BSR:  dec.op = iaids_pkg::OP_BSR;
			iaids_pkg::CMD_DISP: dec.op = iaids_pkg::OP_DISP;
			default:             legal  = 1'b0;
		endcase
	end

	assign push = request.valid && request.ready && legal;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= 1'b0;
			wr_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end
endmodule

### design/iaids_back.sv
// Back part: element memory, fill count and the sequencer that shifts, searches and displays.
// Depends on iaids_pkg and iaids_ifs.
module iaids_back (
	input  logic              clk,
	input  logic              arst_n,
	input  iaids_pkg::item_t  head,
	input  logic              head_valid,
	output logic              pop,
	iaids_rsp_if.source       result
);
	localparam int IW = iaids_pkg::IDX_W;
	localparam int CW = iaids_pkg::CNT_W;

	iaids_pkg::bstate_t state_q, state_d;

	logic [31:0]  mem [iaids_pkg::DEPTH];
	logic [31:0]  rd_q;
	logic         we, re;
	logic [IW-1:0] wa, ra;
	logic [31:0]  wd;

	logic [CW-1:0] cnt_q;
	logic [IW-1:0] ptr_q, stop_q, wa_q, mid_q;
	logic         up_q, pend_q, iss_q, disp_q, last_q;
	logic [31:0]  val_q, key_q;
	logic [CW-1:0] lo_q, hi_q;
	iaids_pkg::status_t st_q;
	logic [IW-1:0] pos_q;

	logic         out_valid_q, out_last_q;
	iaids_pkg::status_t out_st_q;
	logic [IW-1:0] out_pos_q;
	logic [31:0]  out_data_q;
	logic [CW-1:0] out_cnt_q;

	logic         out_free;
	logic         bad;
	iaids_pkg::status_t chk_st;
	logic [IW-1:0] src;
	logic         match;
	logic [CW:0]  msum;
	logic [IW-1:0] mid;
	logic [IW-1:0] disp_stop;

	assign out_free = !out_valid_q || result.ready;
	assign pop      = head_valid && (state_q == iaids_pkg::S_IDLE);
	assign src      = up_q ? (ptr_q - 1'b1) : (ptr_q + 1'b1);
	assign match    = pend_q && (rd_q == key_q);
	assign msum     = {1'b0, lo_q} + {1'b0, hi_q} - 1'b1;
	assign mid      = msum[IW:1];
	assign disp_stop = (int'(cnt_q) > iaids_pkg::MAX_RES) ?
		IW'(iaids_pkg::MAX_RES - 1) : IW'(cnt_q - 1'b1);

	always_comb begin
		bad    = 1'b0;
		chk_st = iaids_pkg::ST_OK;
		case (head.op)
			iaids_pkg::OP_INS: begin
				if (int'(cnt_q) >= iaids_pkg::DEPTH) begin
					bad    = 1'b1;
					chk_st = iaids_pkg::ST_FULL;
				end else if (int'(head.index) > int'(cnt_q)) begin
					bad    = 1'b1;
					chk_st = iaids_pkg::ST_BADIDX;
				end
			end
			iaids_pkg::OP_DEL: begin
				if (cnt_q == '0) begin
					bad    = 1'b1;
					chk_st = iaids_pkg::ST_EMPTY;
				end else if (int'(head.index) >= int'(cnt_q)) begin
					bad    = 1'b1;
					chk_st = iaids_pkg::ST_BADIDX;
				end
			end
			default: begin
				if (cnt_q == '0) begin
					bad    = 1'b1;
					chk_st = iaids_pkg::ST_EMPTY;
				end
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		wa = '0;
		wd = '0;
		re = 1'b0;
		ra = '0;
		case (state_q)
			iaids_pkg::S_IDLE: begin
				if (head_valid) begin
					if (bad) begin
						state_d = iaids_pkg::S_EMIT;
					end else begin
						case (head.op)
							iaids_pkg::OP_INS: state_d = iaids_pkg::S_SHIFT;
							iaids_pkg::OP_DEL: state_d = iaids_pkg::S_SHIFT;
							iaids_pkg::OP_LSR: state_d = iaids_pkg::S_LSRCH;
							iaids_pkg::OP_BSR: state_d = iaids_pkg::S_BRD;
							default:           state_d = iaids_pkg::S_DRD;
						endcase
					end
				end
			end
			iaids_pkg::S_SHIFT: begin
				if (pend_q) begin
					we = 1'b1;
					wa = wa_q;
					wd = rd_q;
				end
				if (ptr_q != stop_q) begin
					re = 1'b1;
					ra = src;
				end else if (!pend_q) begin
					if (up_q) begin
						we = 1'b1;
						wa = stop_q;
						wd = val_q;
					end
					state_d = iaids_pkg::S_EMIT;
				end
			end
			iaids_pkg::S_LSRCH: begin
				if (match) begin
					state_d = iaids_pkg::S_EMIT;
				end else if (iss_q) begin
					re = 1'b1;
					ra = ptr_q;
				end else begin
					state_d = iaids_pkg::S_EMIT;
				end
			end
			iaids_pkg::S_BRD: begin
				if (lo_q < hi_q) begin
					re = 1'b1;
					ra = mid;
					state_d = iaids_pkg::S_BCMP;
				end else begin
					state_d = iaids_pkg::S_EMIT;
				end
			end
			iaids_pkg::S_BCMP: begin
				if (rd_q == key_q) begin
					state_d = iaids_pkg::S_EMIT;
				end else begin
					state_d = iaids_pkg::S_BRD;
				end
			end
			iaids_pkg::S_DRD: begin
				re = 1'b1;
				ra = ptr_q;
				state_d = iaids_pkg::S_EMIT;
			end
			iaids_pkg::S_EMIT: begin
				if (out_free) begin
					state_d = (disp_q && !last_q) ? iaids_pkg::S_DRD : iaids_pkg::S_IDLE;
				end
			end
			default: state_d = iaids_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iaids_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
			iss_q  <= 1'b0;
			disp_q <= 1'b0;
			last_q <= 1'b1;
			ptr_q  <= '0;
			stop_q <= '0;
			wa_q   <= '0;
			mid_q  <= '0;
			up_q   <= 1'b0;
			val_q  <= '0;
			key_q  <= '0;
			lo_q   <= '0;
			hi_q   <= '0;
			st_q   <= iaids_pkg::ST_OK;
			pos_q  <= '0;
		end else begin
			case (state_q)
				iaids_pkg::S_IDLE: begin
					if (pop) begin
						val_q  <= head.value;
						key_q  <= head.key;
						disp_q <= 1'b0;
						last_q <= 1'b1;
						pos_q  <= '0;
						pend_q <= 1'b0;
						st_q   <= chk_st;
						if (!bad) begin
							case (head.op)
								iaids_pkg::OP_INS: begin
									cnt_q  <= cnt_q + 1'b1;
									ptr_q  <= IW'(cnt_q);
									stop_q <= IW'(head.index);
									up_q   <= 1'b1;
								end
								iaids_pkg::OP_DEL: begin
									cnt_q  <= cnt_q - 1'b1;
									ptr_q  <= IW'(head.index);
									stop_q <= IW'(cnt_q - 1'b1);
									up_q   <= 1'b0;
								end
								iaids_pkg::OP_LSR: begin
									ptr_q <= IW'(cnt_q - 1'b1);
									iss_q <= 1'b1;
									st_q  <= iaids_pkg::ST_NOTFOUND;
								end
								iaids_pkg::OP_BSR: begin
									lo_q <= '0;
									hi_q <= cnt_q;
									st_q <= iaids_pkg::ST_NOTFOUND;
								end
								default: begin
									ptr_q  <= '0;
									stop_q <= disp_stop;
									disp_q <= 1'b1;
								end
							endcase
						end
					end
				end
				iaids_pkg::S_SHIFT: begin
					if (ptr_q != stop_q) begin
						wa_q   <= ptr_q;
						pend_q <= 1'b1;
						ptr_q  <= src;
					end else begin
						pend_q <= 1'b0;
					end
				end
				iaids_pkg::S_LSRCH: begin
					if (match) begin
						st_q  <= iaids_pkg::ST_OK;
						pos_q <= wa_q;
					end else if (iss_q) begin
						wa_q   <= ptr_q;
						pend_q <= 1'b1;
						if (ptr_q == '0) begin
							iss_q <= 1'b0;
						end else begin
							ptr_q <= ptr_q - 1'b1;
						end
					end
				end
				iaids_pkg::S_BRD: begin
					mid_q <= mid;
				end
				iaids_pkg::S_BCMP: begin
					if (rd_q == key_q) begin
						st_q  <= iaids_pkg::ST_OK;
						pos_q <= mid_q;
					end else if ($signed(rd_q) > $signed(key_q)) begin
						hi_q <= CW'(mid_q);
					end else begin
						lo_q <= CW'(mid_q) + 1'b1;
					end
				end
				iaids_pkg::S_DRD: begin
					pos_q  <= ptr_q;
					last_q <= (ptr_q == stop_q);
				end
				iaids_pkg::S_EMIT: begin
					if (out_free && disp_q && !last_q) begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				default: pend_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == iaids_pkg::S_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == iaids_pkg::S_EMIT) begin
			out_st_q   <= st_q;
			out_pos_q  <= pos_q;
			out_data_q <= disp_q ? rd_q : '0;
			out_cnt_q  <= cnt_q;
			out_last_q <= last_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.status   = out_st_q;
	assign result.position = 4'(out_pos_q);
	assign result.data     = out_data_q;
	assign result.count    = 5'(out_cnt_q);
	assign result.last     = out_last_q;
endmodule

### design/indexed_array_insert_delete_search.sv
// Top level of the indexed array block: front queue and back sequencer.
// Depends on iaids_pkg, iaids_ifs, iaids_front and iaids_back.
//
// Usage:
// request carries one command beat (cmd, index, value, key); result carries
// result beats (status, position, data, count, last), valid/ready on both.
// Insert and delete move one element per cycle in the back sequencer,
// through the element memory's separate read and write ports.
// Binary search reads the middle element and then compares it for each probe;
// display reads each element and then emits it. Each command ends by loading
// the output register; errors go straight to it.
// The front holds two commands, so new beats are taken while the back works
// and while a result waits. Unused command codes are taken and dropped.
// Reset empties the array and the queue and clears result valid; memory
// contents are not cleared. When the receiver stalls, the result holds and
// the back stops after its next result; the queue then fills and ready drops.
module indexed_array_insert_delete_search (
	input  logic         clk,
	input  logic         arst_n,
	iaids_req_if.sink    request,
	iaids_rsp_if.source  result
);
	iaids_pkg::item_t head;
	logic             head_valid;
	logic             pop;

	iaids_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.request    (request),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	iaids_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.result     (result)
	);
endmodule

### design/iaids_checker.sv
// Port-level checker for the indexed array block, bound to the top level.
// Depends on iaids_pkg and the defines header.
`include "indexed_array_insert_delete_search_defines.svh"

module iaids_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [2:0]  status,
	input logic [3:0]  position,
	input logic [31:0] data,
	input logic [4:0]  count,
	input logic        last
);
	`IAIDS_ASSERT_NXT(a_hold, valid && !ready, valid && $stable(status) && $stable(data) && $stable(last))
	`IAIDS_ASSERT_NOW(a_empty_cnt, valid && status == iaids_pkg::ST_EMPTY, count == '0)
	`IAIDS_ASSERT_NOW(a_full_cnt, valid && status == iaids_pkg::ST_FULL, int'(count) == iaids_pkg::DEPTH)
	`IAIDS_ASSERT_NOW(a_err_single, valid && status != iaids_pkg::ST_OK, last && data == '0 && position == '0)
	`IAIDS_ASSERT_NOW(a_cnt_range, valid, int'(count) <= iaids_pkg::DEPTH)
endmodule

bind indexed_array_insert_delete_search iaids_checker u_iaids_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.valid    (result.valid),
	.ready    (result.ready),
	.status   (result.status),
	.position (result.position),
	.data     (result.data),
	.count    (result.count),
	.last     (result.last)
);
